>>> src/plic_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
// Used by plic_cell, plic_div and piecewise_linear_interpolator; depends on nothing.
`default_nettype none

package plic_pkg;

	localparam int DATA_W    = 32;
	localparam int IDX_W     = 6;
	localparam int SLOT_COUNT = 64;
	localparam int CNT_W     = 7;
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 32;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 7'd2;

	// Load beat broadcast to every cell.
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] coord;
		logic [DATA_W-1:0] weight;
	} plic_load_t;

	// Query token walking down the row of cells.
	typedef struct packed {
		logic              vld;
		logic              hit;
		logic              exact;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] c0;
		logic [DATA_W-1:0] w0;
		logic [DATA_W-1:0] c1;
		logic [DATA_W-1:0] w1;
	} plic_tok_t;

endpackage

`default_nettype wire

>>> src/plic_cell.sv
// One breakpoint cell: holds a coordinate and weight and passes the query token on.
// Depends on plic_pkg.
`default_nettype none

module plic_cell #(
	parameter int CELL_INDEX = 0,
	parameter int CW         = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CW-1:0]       n_used,
	input  plic_pkg::plic_load_t ld,
	input  plic_pkg::plic_tok_t  tok_in,
	output plic_pkg::plic_tok_t  tok_out
);
	import plic_pkg::*;

	localparam logic [CW-1:0]    IDX         = CW'(CELL_INDEX);
	localparam bit               FIRST       = (CELL_INDEX == 0);
	localparam bit               ADDRESSABLE = (CELL_INDEX < SLOT_COUNT);
	localparam logic [IDX_W-1:0] SLOT        = IDX_W'(CELL_INDEX % SLOT_COUNT);

	logic [DATA_W-1:0] coord_q;
	logic [DATA_W-1:0] weight_q;
	logic              vld_q;
	plic_tok_t         tok_q;
	plic_tok_t         tok_nxt;

	logic active;
	logic last;
	logic x_le;
	logic x_ge;
	logic x_eq;
	logic override;

	always_comb begin
		active   = IDX < n_used;
		last     = IDX == (n_used - CW'(1));
		x_le     = $signed(tok_in.x) <= $signed(coord_q);
		x_ge     = $signed(tok_in.x) >= $signed(coord_q);
		x_eq     = tok_in.x == coord_q;
		override = last && x_ge;
		tok_nxt  = tok_in;
		if (active && (!tok_in.hit || override)) begin
			tok_nxt.c0    = tok_in.c1;
			tok_nxt.w0    = tok_in.w1;
			tok_nxt.c1    = coord_q;
			tok_nxt.w1    = weight_q;
			tok_nxt.hit   = x_le || override;
			tok_nxt.exact = FIRST || x_eq || override;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.en && ADDRESSABLE && (ld.idx == SLOT)) begin
			coord_q  <= ld.coord;
			weight_q <= ld.weight;
		end
		tok_q <= tok_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.vld;
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

endmodule

`default_nettype wire

>>> src/plic_div.sv
// Restoring divider producing the fraction bits of num / den with num below den.
// Depends on plic_pkg.
`default_nettype none

module plic_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [plic_pkg::DATA_W-1:0] num,
	input  logic [plic_pkg::DATA_W-1:0] den,
	output logic                       done,
	output logic [FRAC_BITS-1:0]       quot
);
	import plic_pkg::*;

	localparam int KW = $clog2(FRAC_BITS + 1);

	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [KW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;
	logic              q_bit;

	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, den_q};
		q_bit   = shifted >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], q_bit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= KW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - KW'(1);
				if (cnt_q == KW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

>>> src/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator: row of breakpoint cells, divider, blend.
// Depends on plic_pkg, plic_cell and plic_div.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: index, coord, weight, query; s_tuser: command
// m_*      out  m_tvalid/m_tready  m_tdata: interp_value; m_tuser: segment_found
// cfg_*    in   cfg_wr_en          cfg_wr_data: point_count
//
// A load beat writes the addressed cell as it is accepted. A query beat's token walks all
// TABLE_DEPTH cells one per cycle; if a segment is hit but not exactly, the divider then
// yields one fraction bit per cycle, followed by the multiply and add states.
// Reset clears all control state; the table holds garbage until loaded.
// A finished result waits in the output register while the next beat is taken.
`default_nettype none

module piecewise_linear_interpolator #(
	parameter int TABLE_DEPTH = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// point_index[5:0], point_coord[37:6], point_weight[69:38], query_x[101:70], zero pad
	input  logic [plic_pkg::S_TDATA_W-1:0] s_tdata,
	// command[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// interp_value[31:0]
	output logic [plic_pkg::M_TDATA_W-1:0] m_tdata,
	// segment_found[0]
	output logic                          m_tuser,
	input  logic                          cfg_wr_en,
	input  logic [plic_pkg::CNT_W-1:0]    cfg_wr_data
);
	import plic_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = FRAC_BITS + DATA_W + 1;
	localparam logic [DATA_W-1:0] NOT_FOUND_VAL = ~((32'd1 << FRAC_BITS) - 32'd1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_ADD  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  point_count_q;
	logic [CW-1:0]     n_used;

	logic              s_accept;
	plic_load_t        ld;
	plic_tok_t         head;
	plic_tok_t         tok [TABLE_DEPTH+1];
	plic_tok_t         tail;
	logic [TABLE_DEPTH-1:0] tok_vld;

	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_num;
	logic [DATA_W-1:0] div_den;
	logic [FRAC_BITS-1:0] div_quot;

	logic [DATA_W-1:0] w0_q;
	logic [DATA_W:0]   mag_q;
	logic              neg_q;
	logic [PW-1:0]     prod_q;
	logic [DATA_W-1:0] res_q;
	logic              found_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	logic [DATA_W:0]   dw;
	logic [DATA_W:0]   delta_mag;
	logic [DATA_W+2:0] delta_s;
	logic [DATA_W+2:0] sum;
	logic [DATA_W-1:0] sum_sat;
	logic              out_free;

	always_comb begin
		if (point_count_q < CNT_W'(2)) begin
			n_used = CW'(2);
		end else if (int'(point_count_q) > TABLE_DEPTH) begin
			n_used = CW'(TABLE_DEPTH);
		end else begin
			n_used = CW'(point_count_q);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		ld.en     = s_accept && (s_tuser == CMD_LOAD);
		ld.idx    = s_tdata[5:0];
		ld.coord  = s_tdata[37:6];
		ld.weight = s_tdata[69:38];
		head      = '0;
		head.vld  = s_accept && (s_tuser == CMD_QUERY);
		head.x    = s_tdata[101:70];
	end

	assign tok[0] = head;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		plic_cell #(
			.CELL_INDEX(k),
			.CW        (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.n_used (n_used),
			.ld     (ld),
			.tok_in (tok[k]),
			.tok_out(tok[k+1])
		);
		assign tok_vld[k] = tok[k+1].vld;
	end

	assign tail = tok[TABLE_DEPTH];

	assign div_start = (state_q == ST_SCAN) && tail.vld && tail.hit && !tail.exact;
	assign div_num   = tail.x - tail.c0;
	assign div_den   = tail.c1 - tail.c0;

	plic_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_comb begin
		dw        = {tail.w1[DATA_W-1], tail.w1} - {tail.w0[DATA_W-1], tail.w0};
		delta_mag = prod_q[FRAC_BITS +: DATA_W+1];
		delta_s   = neg_q ? -{2'b00, delta_mag} : {2'b00, delta_mag};
		sum       = {{3{w0_q[DATA_W-1]}}, w0_q} + delta_s;
		if (!sum[DATA_W+2] && (sum[DATA_W+1:DATA_W-1] != 3'b000)) begin
			sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sum[DATA_W+2] && (sum[DATA_W+1:DATA_W-1] != 3'b111)) begin
			sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sum_sat = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			w0_q  <= tail.w0;
			neg_q <= dw[DATA_W];
			mag_q <= dw[DATA_W] ? -dw : dw;
		end
		if (div_done) begin
			prod_q <= PW'(div_quot) * PW'(mag_q);
		end
		if ((state_q == ST_SCAN) && tail.vld) begin
			if (!tail.hit) begin
				res_q   <= NOT_FOUND_VAL;
				found_q <= 1'b0;
			end else begin
				res_q   <= tail.w1;
				found_q <= 1'b1;
			end
		end else if (state_q == ST_ADD) begin
			res_q   <= sum_sat;
			found_q <= 1'b1;
		end
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			point_count_q <= COUNT_RESET;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				point_count_q <= cfg_wr_data;
			end
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tok[0].vld) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.vld) begin
						state_q <= div_start ? ST_DIV : ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= res_q;
			m_tuser_q <= found_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one query token in the cell row");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (div_num < div_den))
		else $error("divider started with numerator not below denominator");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_vld != '0) |-> (state_q == ST_SCAN))
		else $error("query token in flight outside the scan state");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == NOT_FOUND_VAL))
		else $error("not-found beat carries a value other than minus one");

endmodule

`default_nettype wire
